FILE: hdl/tsrr_pkg.sv
// Package for the round-robin thread slot scheduler.
// Holds field widths, action, slot state and status codes, and the result word type.
// No dependencies.
package tsrr_pkg;

  localparam int NumSlotsDef = 64;

  localparam int ActW  = 2;
  localparam int IdW   = 7;
  localparam int StatW = 3;
  localparam int StW   = 2;

  // Actions.
  localparam logic [ActW-1:0] ACT_CREATE = 2'd0;
  localparam logic [ActW-1:0] ACT_YIELD  = 2'd1;
  localparam logic [ActW-1:0] ACT_EXIT   = 2'd2;
  localparam logic [ActW-1:0] ACT_JOIN   = 2'd3;

  // Slot states.
  localparam logic [StW-1:0] ST_FREE     = 2'd0;
  localparam logic [StW-1:0] ST_RUNNABLE = 2'd1;
  localparam logic [StW-1:0] ST_RUNNING  = 2'd2;
  localparam logic [StW-1:0] ST_FINISHED = 2'd3;

  // Status codes.
  localparam logic [StatW-1:0] STAT_OK           = 3'd0;
  localparam logic [StatW-1:0] STAT_FULL         = 3'd1;
  localparam logic [StatW-1:0] STAT_NOT_FINISHED = 3'd2;
  localparam logic [StatW-1:0] STAT_NONE         = 3'd3;
  localparam logic [StatW-1:0] STAT_INVALID      = 3'd4;

  // One result word, handed from the sequencer to the output register.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   result_id;
    logic [IdW-1:0]   running_id;
    logic             switched;
  } res_t;

endpackage

FILE: hdl/tsrr_ram.sv
// Slot state memory: one write port, one read port, registered read data.
// Depends on tsrr_pkg for the slot state width.
module tsrr_ram import tsrr_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] waddr_i,
  input  logic [StW-1:0]               wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] raddr_i,
  output logic [StW-1:0]               rdata_o
);

  logic [StW-1:0] mem_q [NUM_SLOTS];
  logic [StW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tsrr_seq.sv
// Sequencer of the thread slot scheduler: clearing pass, slot scans, join check
// and the running slot and live count registers. Depends on tsrr_pkg and tsrr_ram.
module tsrr_seq import tsrr_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ActW-1:0] action_i,
  input  logic [IdW-1:0]  target_id_i,
  output logic            busy_o,
  output logic            done_o,
  output res_t            res_o,
  input  logic            out_free_i
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [SW-1:0] LastSlot = SW'(NUM_SLOTS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_JCHK  = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [ActW-1:0]  act_q, act_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [SW-1:0]    cur_q, cur_d;
  logic             cur_vld_q, cur_vld_d;
  logic [LW-1:0]    live_q, live_d;
  logic [SW-1:0]    iss_addr_q, iss_addr_d;
  logic [LW-1:0]    iss_left_q, iss_left_d;
  logic             chk_vld_q, chk_vld_d;
  logic [SW-1:0]    chk_addr_q, chk_addr_d;
  logic [StW-1:0]   match_q, match_d;
  logic [StatW-1:0] status_q, status_d;
  logic [IdW-1:0]   rid_q, rid_d;
  logic             sw_q, sw_d;

  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [StW-1:0]   ram_wdata;
  logic             ram_re;
  logic [SW-1:0]    ram_raddr;
  logic [StW-1:0]   ram_rdata;

  logic             hit;
  logic [SW-1:0]    cur_next;
  logic [SW:0]      cur_p1;
  logic [SW:0]      chk_p1;
  logic [SW:0]      slot_p1;

  tsrr_ram #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hit      = chk_vld_q && (ram_rdata == match_q);
  assign cur_next = (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
  assign cur_p1   = {1'b0, cur_q} + 1'b1;
  assign chk_p1   = {1'b0, chk_addr_q} + 1'b1;
  assign slot_p1  = {1'b0, slot_q} + 1'b1;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    slot_d     = slot_q;
    cur_d      = cur_q;
    cur_vld_d  = cur_vld_q;
    live_d     = live_q;
    iss_addr_d = iss_addr_q;
    iss_left_d = iss_left_q;
    chk_vld_d  = chk_vld_q;
    chk_addr_d = chk_addr_q;
    match_d    = match_q;
    status_d   = status_q;
    rid_d      = rid_q;
    sw_d       = sw_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ST_FREE;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = iss_addr_q;
        ram_wdata  = ST_FREE;
        iss_addr_d = iss_addr_q + 1'b1;
        if (iss_addr_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          act_d     = action_i;
          status_d  = STAT_OK;
          rid_d     = '0;
          sw_d      = 1'b0;
          chk_vld_d = 1'b0;
          case (action_i)
            ACT_CREATE: begin
              if (live_q == LW'(NUM_SLOTS)) begin
                status_d = STAT_FULL;
                state_d  = S_DONE;
              end else begin
                iss_addr_d = '0;
                iss_left_d = LW'(NUM_SLOTS);
                match_d    = ST_FREE;
                state_d    = S_SCAN;
              end
            end
            ACT_YIELD: begin
              match_d = ST_RUNNABLE;
              state_d = S_SCAN;
              if (cur_vld_q) begin
                // Every slot but the running one, starting just after it.
                iss_addr_d = cur_next;
                iss_left_d = LW'(NUM_SLOTS - 1);
              end else begin
                iss_addr_d = '0;
                iss_left_d = LW'(NUM_SLOTS);
              end
            end
            ACT_EXIT: begin
              if (cur_vld_q) begin
                ram_we    = 1'b1;
                ram_waddr = cur_q;
                ram_wdata = ST_FINISHED;
                cur_vld_d = 1'b0;
                if (live_q != '0) begin
                  live_d = live_q - 1'b1;
                end
              end else begin
                status_d = STAT_NONE;
              end
              state_d = S_DONE;
            end
            ACT_JOIN: begin
              if ((target_id_i == '0) || (int'(target_id_i) > NUM_SLOTS)) begin
                status_d = STAT_INVALID;
                state_d  = S_DONE;
              end else begin
                slot_d    = SW'(target_id_i - 1'b1);
                ram_re    = 1'b1;
                ram_raddr = SW'(target_id_i - 1'b1);
                state_d   = S_JCHK;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (act_q == ACT_CREATE) begin
            ram_we    = 1'b1;
            ram_waddr = chk_addr_q;
            ram_wdata = ST_RUNNABLE;
            live_d    = live_q + 1'b1;
            rid_d     = IdW'(chk_p1);
            state_d   = S_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = chk_addr_q;
            ram_wdata = ST_RUNNING;
            cur_d     = chk_addr_q;
            cur_vld_d = 1'b1;
            sw_d      = 1'b1;
            slot_d    = cur_q;
            state_d   = cur_vld_q ? S_WR2 : S_DONE;
          end
        end else if ((iss_left_q == '0) && !chk_vld_q) begin
          // Scan ran out. A running slot with no other runnable one keeps running.
          if (act_q == ACT_CREATE) begin
            status_d = STAT_FULL;
          end else if (!cur_vld_q) begin
            status_d = STAT_NONE;
          end
          state_d = S_DONE;
        end else begin
          if (iss_left_q != '0) begin
            ram_re     = 1'b1;
            ram_raddr  = iss_addr_q;
            iss_addr_d = (iss_addr_q == LastSlot) ? '0 : iss_addr_q + 1'b1;
            iss_left_d = iss_left_q - 1'b1;
            chk_vld_d  = 1'b1;
            chk_addr_d = iss_addr_q;
          end else begin
            chk_vld_d = 1'b0;
          end
        end
      end

      S_JCHK: begin
        if (ram_rdata == ST_FINISHED) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = ST_FREE;
          rid_d     = IdW'(slot_p1);
        end else if (ram_rdata == ST_FREE) begin
          status_d = STAT_INVALID;
        end else begin
          status_d = STAT_NOT_FINISHED;
        end
        state_d = S_DONE;
      end

      S_WR2: begin
        // The slot that was running goes back to runnable.
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = ST_RUNNABLE;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_q      <= '0;
      cur_vld_q  <= 1'b0;
      live_q     <= '0;
      iss_addr_q <= '0;
      iss_left_q <= '0;
      chk_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      cur_vld_q  <= cur_vld_d;
      live_q     <= live_d;
      iss_addr_q <= iss_addr_d;
      iss_left_q <= iss_left_d;
      chk_vld_q  <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    slot_q     <= slot_d;
    chk_addr_q <= chk_addr_d;
    match_q    <= match_d;
    status_q   <= status_d;
    rid_q      <= rid_d;
    sw_q       <= sw_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    res_o.status     = status_q;
    res_o.result_id  = rid_q;
    res_o.running_id = cur_vld_q ? IdW'(cur_p1) : '0;
    res_o.switched   = sw_q;
  end

endmodule

FILE: hdl/thread_slot_round_robin_scheduler_core.sv
// Top level of the round-robin thread slot scheduler.
// Holds the output register; depends on tsrr_pkg and tsrr_seq (which holds tsrr_ram).
//
//   Channel   Direction  Handshake                  Word
//   input     in         in_valid_i / in_stall_o    action_i, target_id_i
//   output    out        out_valid_o / out_stall_i  status_o, result_id_o,
//                                                   running_id_o, switched_o
//
// Each input word gives exactly one output word. The slot states live in a single-port-write,
// registered-read memory, and the scan over it issues one read per cycle. A yield that demotes
// the old running slot writes it back in a state of its own (S_WR2) but scans one slot fewer.
// After reset a clearing pass writes every slot free, one slot per cycle, and in_stall_o
// stays high until it is done.
// The output word waits in its register while out_stall_i is high; the next input word is
// taken as soon as the sequencer has handed its word over, even while the output still waits.
module thread_slot_round_robin_scheduler_core import tsrr_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ActW-1:0]  action_i,
  input  logic [IdW-1:0]   target_id_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic [IdW-1:0]   result_id_o,
  output logic [IdW-1:0]   running_id_o,
  output logic             switched_o
);

  logic busy;
  logic start;
  logic done;
  logic out_free;
  res_t res;
  logic out_valid_q, out_valid_d;
  res_t out_word_q;

  // The sequencer is idle only when it can take a new word.
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // The output register can load when it is empty or its word leaves this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  tsrr_seq #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_i),
    .target_id_i (target_id_i),
    .busy_o      (busy),
    .done_o      (done),
    .res_o       (res),
    .out_free_i  (out_free)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_word_q.status;
  assign result_id_o  = out_word_q.result_id;
  assign running_id_o = out_word_q.running_id;
  assign switched_o   = out_word_q.switched;

endmodule

FILE: tb/tsrr_sched_checker.sv
// Checker for the round-robin thread slot scheduler: keeps its own slot table,
// predicts one result word per accepted input word and compares it field by field.
// Depends on tsrr_pkg for widths, codes and the res_t result word.
`timescale 1ns / 1ps

module tsrr_sched_checker import tsrr_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ActW-1:0]  action_i,
  input  logic [IdW-1:0]   target_id_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [StatW-1:0] status_i,
  input  logic [IdW-1:0]   result_id_i,
  input  logic [IdW-1:0]   running_id_i,
  input  logic             switched_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  logic [StW-1:0] slot_st [NUM_SLOTS];
  int             run_slot;
  bit             run_valid;
  int             live_cnt;
  res_t           sched_results_q [$];
  res_t           want;
  int             mismatches = 0;

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // Applies one action to the slot table and returns the word the block must answer with.
  function automatic res_t schedule_step(logic [ActW-1:0] act, logic [IdW-1:0] tgt);
    res_t r;
    int   nxt;
    int   idx;
    int   i;
    r        = '0;
    r.status = STAT_OK;
    nxt      = -1;
    case (act)
      ACT_CREATE: begin
        if (live_cnt < NUM_SLOTS) begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (nxt < 0 && slot_st[i] == ST_FREE) nxt = i;
          end
        end
        if (nxt >= 0) begin
          slot_st[nxt] = ST_RUNNABLE;
          live_cnt++;
          r.result_id = IdW'(nxt + 1);
        end else begin
          r.status = STAT_FULL;
        end
      end
      ACT_YIELD: begin
        if (run_valid) begin
          if (slot_st[run_slot] == ST_RUNNING) slot_st[run_slot] = ST_RUNNABLE;
          // Search starts just after the running slot and wraps back onto it.
          for (i = 1; i <= NUM_SLOTS; i++) begin
            idx = (run_slot + i) % NUM_SLOTS;
            if (nxt < 0 && slot_st[idx] == ST_RUNNABLE) nxt = idx;
          end
          if (nxt >= 0) begin
            r.switched    = (nxt != run_slot);
            run_slot      = nxt;
            slot_st[nxt]  = ST_RUNNING;
          end else begin
            r.status = STAT_NONE;
          end
        end else begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (nxt < 0 && slot_st[i] == ST_RUNNABLE) nxt = i;
          end
          if (nxt >= 0) begin
            run_slot     = nxt;
            run_valid    = 1'b1;
            slot_st[nxt] = ST_RUNNING;
            r.switched   = 1'b1;
          end else begin
            r.status = STAT_NONE;
          end
        end
      end
      ACT_EXIT: begin
        if (run_valid && slot_st[run_slot] == ST_RUNNING) begin
          slot_st[run_slot] = ST_FINISHED;
          if (live_cnt > 0) live_cnt--;
          run_valid = 1'b0;
        end else begin
          r.status = STAT_NONE;
        end
      end
      default: begin
        if (tgt == 0 || tgt > NUM_SLOTS) begin
          r.status = STAT_INVALID;
        end else if (slot_st[tgt - 1] == ST_FINISHED) begin
          slot_st[tgt - 1] = ST_FREE;
          r.result_id      = tgt;
        end else if (slot_st[tgt - 1] == ST_FREE) begin
          r.status = STAT_INVALID;
        end else begin
          r.status = STAT_NOT_FINISHED;
        end
      end
    endcase
    r.running_id = run_valid ? IdW'(run_slot + 1) : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) slot_st[s] = ST_FREE;
      run_slot  = 0;
      run_valid = 1'b0;
      live_cnt  = 0;
      sched_results_q.delete();
      pending_o <= 0;
    end else begin
      // A result can never leave in the cycle its own word is taken, so results go first.
      if (out_valid_i && !out_stall_i) begin
        if (sched_results_q.size() == 0) begin
          $error("result word with nothing expected: status %0d result_id %0d",
                 status_i, result_id_i);
          mismatches++;
        end else begin
          want = sched_results_q.pop_front();
          check_field("status", 8'(want.status), 8'(status_i));
          check_field("result_id", 8'(want.result_id), 8'(result_id_i));
          check_field("running_id", 8'(want.running_id), 8'(running_id_i));
          check_field("switched", 8'(want.switched), 8'(switched_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        sched_results_q.push_back(schedule_step(action_i, target_id_i));
      end
      pending_o <= sched_results_q.size();
    end
    fail_cnt_o <= mismatches;
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the round-robin thread slot scheduler: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on tsrr_pkg, the scheduler core
// and tsrr_sched_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb import tsrr_pkg::*; ();

  localparam int  NUM_SLOTS      = NumSlotsDef;
  localparam real CLK_PERIOD     = 12.0;
  localparam int  RESET_CYCLES   = 6;
  // Words in each random phase; three phases plus the directed part give about 1550,
  // counting the last block of each phase running a little past the mark.
  localparam int  RAND_PER_PHASE = 475;
  // Length of the one long output hold, in cycles.
  localparam int  LONG_HOLD      = 300;
  // A correct run never goes this long without a word moving on either channel:
  // a full scan, the long hold and the random gaps are all far shorter.
  localparam int  QUIET_LIMIT    = 4000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [ActW-1:0]  action_i    = ACT_CREATE;
  logic [IdW-1:0]   target_id_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic [IdW-1:0]   result_id_o;
  logic [IdW-1:0]   running_id_o;
  logic             switched_o;

  int fail_cnt;
  int pending_cnt;

  // Idle rates in percent; the sender's is read only by the stimulus process.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // The stimulus toggles hold_tog to ask for one long hold; the receiver counts it out.
  bit hold_tog  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int quiet_cycles = 0;
  int words_sent   = 0;
  int n_results    = 0;
  int n_full       = 0;
  int n_switched   = 0;

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  thread_slot_round_robin_scheduler_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .target_id_i (target_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .result_id_o (result_id_o),
    .running_id_o(running_id_o),
    .switched_o  (switched_o)
  );

  tsrr_sched_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .action_i    (action_i),
    .target_id_i (target_id_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .result_id_i (result_id_o),
    .running_id_i(running_id_o),
    .switched_i  (switched_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  // Receiver side. Stall is drawn fresh every cycle at the current idle rate, except
  // during the long hold, which this process counts down on its own.
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Watchdog: the run is declared hung when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("thread_slot_round_robin_scheduler_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A few tallies of what came back, for the closing summary only.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (status_o == STAT_FULL) n_full++;
      if (switched_o) n_switched++;
    end
  end

  // Offers one word, with random idle cycles ahead of it, and returns at the edge that
  // takes it. Valid stays high from one word to the next when no idle cycle falls between,
  // so each signal gets exactly one assignment per edge.
  task automatic send_word(input logic [ActW-1:0] act, input logic [IdW-1:0] tgt);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    target_id_i <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // The sender stops and waits until every predicted word has come back. The first edge
  // lets the checker's count catch up with a word taken at the edge we were called on.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Join targets favor the low ids, since create always claims the lowest free slot;
  // a share covers the whole table and a few are out-of-range or zero.
  function automatic logic [IdW-1:0] pick_join_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return IdW'($urandom_range(1, 12));
    if (roll < 88) return IdW'($urandom_range(1, NUM_SLOTS));
    return IdW'($urandom_range(0, (1 << IdW) - 1));
  endfunction

  // A run of mixed scheduler events. Targets of non-join words are random: the block
  // must ignore them.
  task automatic mixed_events(input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      send_word(ACT_CREATE, IdW'($urandom_range(0, (1 << IdW) - 1)));
      else if (roll < 62) send_word(ACT_YIELD, IdW'($urandom_range(0, (1 << IdW) - 1)));
      else if (roll < 78) send_word(ACT_EXIT, IdW'($urandom_range(0, (1 << IdW) - 1)));
      else                send_word(ACT_JOIN, pick_join_id());
    end
  endtask

  // Creates past the table size, so the last few come back as table full.
  task automatic fill_table();
    repeat (NUM_SLOTS + 3) begin
      if ($urandom_range(0, 9) == 0) send_word(ACT_YIELD, '0);
      send_word(ACT_CREATE, IdW'($urandom_range(0, (1 << IdW) - 1)));
    end
  endtask

  // Runs and retires a batch of threads, then joins every id in turn, which frees the
  // finished slots and probes the rest for not-finished and invalid answers.
  task automatic retire_and_join(input int count);
    repeat (count) begin
      send_word(ACT_YIELD, '0);
      send_word(ACT_EXIT, '0);
    end
    for (int id = 1; id <= NUM_SLOTS; id++) send_word(ACT_JOIN, IdW'(id));
  endtask

  // One random phase at the given idle rates. In the pressure phase the receiver is put
  // on a long hold early on while words keep coming, and later the sender pauses until
  // the block has answered everything.
  task automatic random_phase(input int snd_pct, input int rcv_pct, input bit pressure);
    int  start;
    int  roll;
    bit  held;
    bit  paused;
    start        = words_sent;
    held         = 1'b0;
    paused       = 1'b0;
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
    while (words_sent - start < RAND_PER_PHASE) begin
      if (pressure && !held && words_sent - start >= 100) begin
        hold_tog <= ~hold_tog;
        held     = 1'b1;
      end
      if (pressure && !paused && words_sent - start >= 300) begin
        wait_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 7)       fill_table();
      else if (roll < 17) retire_and_join($urandom_range(4, NUM_SLOTS));
      else                mixed_events($urandom_range(15, 45));
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every action from an empty table, each error answer but table full, the id
    // extremes, and yields with nothing running, with one thread and with two.
    send_word(ACT_EXIT, 7'h7F);    // exit with nothing running
    send_word(ACT_YIELD, '0);      // yield with nothing runnable
    send_word(ACT_JOIN, '0);       // id zero is invalid
    send_word(ACT_JOIN, 7'h7F);    // largest field value, far out of range
    send_word(ACT_JOIN, IdW'(NUM_SLOTS + 1));
    send_word(ACT_JOIN, IdW'(NUM_SLOTS)); // top id, slot still free
    send_word(ACT_CREATE, 7'h55);  // takes slot 0, target ignored
    send_word(ACT_JOIN, 7'd1);     // runnable, so not finished
    send_word(ACT_YIELD, 7'h2A);   // nothing running: search from slot 0 starts it
    send_word(ACT_YIELD, '0);      // lone thread picked again, no switch
    send_word(ACT_CREATE, '0);
    send_word(ACT_JOIN, 7'd2);     // runnable
    send_word(ACT_YIELD, '0);      // round robin moves to the second thread
    send_word(ACT_JOIN, 7'd2);     // running, so not finished
    send_word(ACT_EXIT, '0);
    send_word(ACT_JOIN, 7'd2);     // finished: freed
    send_word(ACT_JOIN, 7'd2);     // now free, so invalid
    send_word(ACT_YIELD, '0);      // restarts the first thread from slot 0
    send_word(ACT_EXIT, '0);
    send_word(ACT_EXIT, '0);       // second exit finds nothing running
    send_word(ACT_JOIN, 7'd1);
    wait_drained();

    random_phase(21, 74, 1'b0);
    random_phase(74, 21, 1'b0);
    random_phase(0, 0, 1'b1);

    // Give any stray extra word time to show up at the checker.
    repeat (NUM_SLOTS + 8) @(posedge clk_i);

    $display("Summary: %0d words sent over a directed part and three idling phases, %0d results.",
             words_sent, n_results);
    $display("Summary: %0d table-full answers, %0d switches, one long output hold.",
             n_full, n_switched);
    if (fail_cnt == 0) begin
      $display("thread_slot_round_robin_scheduler_core verification clean");
    end else begin
      $display("thread_slot_round_robin_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

FILE: thread_slot_round_robin_scheduler_core.f
hdl/tsrr_pkg.sv
hdl/tsrr_ram.sv
hdl/tsrr_seq.sv
hdl/thread_slot_round_robin_scheduler_core.sv
tb/tsrr_sched_checker.sv
tb/tb.sv
